// ----- sv/assert_macros.svh -----
// assertion macros for the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AST_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AST_IMP(lbl, clk, rstn, ante, cons)
`define AST_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/ikht_pkg.sv -----
// types and constants of the integer key hash table
`default_nettype none
package ikht_pkg;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [3:0] HASH_BITS_RST = 4'd10;

  localparam logic [31:0] JK_C0 = 32'h7ed55d16;
  localparam logic [31:0] JK_C1 = 32'hc761c23c;
  localparam logic [31:0] JK_C2 = 32'h165667b1;
  localparam logic [31:0] JK_C3 = 32'hd3a2646c;
  localparam logic [31:0] JK_C4 = 32'hfd7046c5;
  localparam logic [31:0] JK_C5 = 32'hb55a4f09;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value_in;
  } in_beat_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] value_out;
    logic [1:0]  status;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_UPDATE
  } state_t;

endpackage
`default_nettype wire

// ----- sv/ikht_mem.sv -----
// bucket memory: one write port, one read port with registered data
`default_nettype none
module ikht_mem
  import ikht_pkg::*;
#(
  parameter int AW = 10,
  parameter int DW = 260
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- sv/ikht_hash.sv -----
// jenkins 32-bit integer hash in two halves, masked to the bucket width
`default_nettype none
module ikht_hash
  import ikht_pkg::*;
#(
  parameter int MAX_HASH_BITS = 10
) (
  input  wire logic                     clk,
  input  wire logic                     load,
  input  wire logic [31:0]              key,
  input  wire logic [3:0]               hash_bits,
  output logic      [MAX_HASH_BITS-1:0] bucket
);

  localparam logic [4:0] HB_MAX = 5'(MAX_HASH_BITS);

  logic [31:0] a1, a2, a3;
  logic [31:0] b4, b5, b6;
  logic [31:0] front_r;
  logic [4:0]  hb_req, hb;
  logic [MAX_HASH_BITS-1:0] mask;

  // first three mixing steps, registered when the beat is taken
  always_comb begin
    a1 = (key + JK_C0) + (key << 12);
    a2 = (a1 ^ JK_C1) ^ (a1 >> 19);
    a3 = (a2 + JK_C2) + (a2 << 5);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front_r <= a3;
    end
  end

  always_comb begin
    b4 = (front_r + JK_C3) ^ (front_r << 9);
    b5 = (b4 + JK_C4) + (b4 << 3);
    b6 = (b5 ^ JK_C5) ^ (b5 >> 16);
  end

  // clamp the width to one .. MAX_HASH_BITS
  always_comb begin
    hb_req = {1'b0, hash_bits};
    if (hb_req == 5'd0) begin
      hb = 5'd1;
    end else if (hb_req > HB_MAX) begin
      hb = HB_MAX;
    end else begin
      hb = hb_req;
    end
    mask   = ~({MAX_HASH_BITS{1'b1}} << hb);
    bucket = b6[MAX_HASH_BITS-1:0] & mask;
  end

endmodule
`default_nettype wire

// ----- sv/ikht_update.sv -----
// way compare, result and write-back row for one bucket
`default_nettype none
module ikht_update
  import ikht_pkg::*;
#(
  parameter int WAYS = 4
) (
  input  wire logic [WAYS*65-1:0] row_rd,
  input  wire in_beat_t           item,
  output logic      [WAYS*65-1:0] row_wr,
  output logic                    wr_en,
  output out_beat_t               res
);

  localparam int KEY_LO = WAYS;
  localparam int VAL_LO = WAYS + WAYS*32;

  logic [WAYS-1:0] vld;
  logic [WAYS-1:0] match_oh, free_oh;
  logic            found, have_free;
  logic [31:0]     vout;

  always_comb begin
    found     = 1'b0;
    have_free = 1'b0;
    match_oh  = '0;
    free_oh   = '0;
    vout      = '0;
    vld       = row_rd[WAYS-1:0];
    // lowest matching way and lowest free way
    for (int w = 0; w < WAYS; w++) begin
      if (vld[w]) begin
        if (!found && row_rd[KEY_LO + w*32 +: 32] == item.key) begin
          found       = 1'b1;
          match_oh[w] = 1'b1;
        end
      end else if (!have_free) begin
        have_free  = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (match_oh[w]) begin
        vout = vout | row_rd[VAL_LO + w*32 +: 32];
      end
    end

    row_wr = row_rd;
    wr_en  = 1'b0;
    res    = '{hit: found, value_out: 32'd0, status: ST_OK};
    case (item.op)
      OP_ADD: begin
        if (found) begin
          res.status = ST_DUPLICATE;
        end else if (have_free) begin
          wr_en = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (free_oh[w]) begin
              row_wr[w]                    = 1'b1;
              row_wr[KEY_LO + w*32 +: 32] = item.key;
              row_wr[VAL_LO + w*32 +: 32] = item.value_in;
            end
          end
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (found) begin
          wr_en = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            if (match_oh[w]) begin
              row_wr[w] = 1'b0;
            end
          end
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        // lookup, also for the unused op code
        if (found) begin
          res.value_out = vout;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/integer_key_hash_table.sv -----
// integer key hash table: top level with sequencer, output register and config
// a taken beat has its first hash half registered; in S_HASH its bucket row is read;
//   in S_UPDATE the row is compared and written back and out_pld loaded once free
// a new beat is taken only in S_IDLE or as the last leaves S_UPDATE, set by the bucket
//   read and write-back on the single-port-pair bucket memory; reset: clearing pass
//   over all 2^MAX_HASH_BITS buckets, in_stall high, config writes taken; hash_bits resets to 10
`default_nettype none
`include "assert_macros.svh"
module integer_key_hash_table
  import ikht_pkg::*;
#(
  parameter int MAX_HASH_BITS = 10,
  parameter int WAYS          = 4
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_pld,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_pld,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [3:0] cfg_data
);

  localparam int AW = MAX_HASH_BITS;
  localparam int DW = WAYS*65;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic [3:0]        hash_bits_r;
  in_beat_t          item_r;
  logic [AW-1:0]     addr_r;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_pld_r;

  logic              in_take, out_free, upd_fire;
  logic [AW-1:0]     bucket;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [DW-1:0]     mem_wdata, row_rd, row_wr;
  logic              upd_we;
  out_beat_t         upd_res;

  ikht_hash #(.MAX_HASH_BITS(MAX_HASH_BITS)) u_hash (
    .clk       (clk),
    .load      (in_take),
    .key       (in_pld.key),
    .hash_bits (hash_bits_r),
    .bucket    (bucket)
  );

  ikht_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (bucket),
    .rdata (row_rd)
  );

  ikht_update #(.WAYS(WAYS)) u_upd (
    .row_rd (row_rd),
    .item   (item_r),
    .row_wr (row_wr),
    .wr_en  (upd_we),
    .res    (upd_res)
  );

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      hash_bits_r <= HASH_BITS_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        hash_bits_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= in_pld;
    end
    if (state_r == S_HASH) begin
      addr_r <= bucket;
    end
    if (upd_fire) begin
      out_pld_r <= upd_res;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    in_stall      = 1'b1;
    upd_fire      = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = row_wr;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        mem_re    = 1'b1;
        state_nxt = S_UPDATE;
      end
      S_UPDATE: begin
        // the read row stays put until the result beat can be loaded
        if (out_free) begin
          upd_fire      = 1'b1;
          mem_we        = upd_we;
          out_valid_nxt = 1'b1;
          in_stall      = 1'b0;
          state_nxt     = in_valid ? S_HASH : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_pld   = out_pld_r;

  `AST_NXT(a_take_hash, clk, rst_n, in_take, state_r == S_HASH)
  `AST_IMP(a_we_src, clk, rst_n, mem_we, state_r == S_CLEAR || state_r == S_UPDATE)
  `AST_IMP(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_UPDATE)
  `AST_IMP(a_add_wr, clk, rst_n, upd_fire && item_r.op == OP_ADD && upd_res.status == ST_OK, mem_we)

endmodule
`default_nettype wire

// ----- bench/ikht_checker.sv -----
// checker for the integer key hash table: mirrors the table and checks every result beat
module ikht_checker
  import ikht_pkg::*;
#(
  parameter int MAX_HASH_BITS = 10,
  parameter int WAYS          = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_beat_t   in_pld,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_beat_t  out_pld,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [3:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  localparam int SLOTS = (1 << MAX_HASH_BITS) * WAYS;

  logic        way_live [SLOTS];
  logic [31:0] way_key  [SLOTS];
  logic [31:0] way_data [SLOTS];
  logic [3:0]  width_reg;
  out_beat_t   due_results [$];
  int          errs;

  function automatic logic [31:0] mix32(logic [31:0] a);
    a = (a + JK_C0) + (a << 12);
    a = (a ^ JK_C1) ^ (a >> 19);
    a = (a + JK_C2) + (a << 5);
    a = (a + JK_C3) ^ (a << 9);
    a = (a + JK_C4) + (a << 3);
    a = (a ^ JK_C5) ^ (a >> 16);
    return a;
  endfunction

  function automatic int unsigned bucket_index(logic [31:0] key);
    int unsigned bits;
    bits = 32'(width_reg);
    if (bits < 1) bits = 1;
    if (bits > MAX_HASH_BITS) bits = MAX_HASH_BITS;
    return mix32(key) & ((32'd1 << bits) - 32'd1);
  endfunction

  // applies one beat to the mirrored table and returns the result it must produce
  function automatic out_beat_t table_access(in_beat_t b);
    int unsigned base;
    int unsigned match;
    int unsigned free_slot;
    bit          found;
    bit          has_free;
    out_beat_t   r;
    base      = bucket_index(b.key) * WAYS;
    match     = 0;
    free_slot = 0;
    found     = 1'b0;
    has_free  = 1'b0;
    r         = '0;
    r.status  = ST_OK;
    for (int w = 0; w < WAYS; w++) begin
      if (way_live[base + w]) begin
        if (!found && way_key[base + w] == b.key) begin
          found = 1'b1;
          match = base + w;
        end
      end else if (!has_free) begin
        has_free  = 1'b1;
        free_slot = base + w;
      end
    end
    case (b.op)
      OP_ADD: begin
        if (found) begin
          r.hit    = 1'b1;
          r.status = ST_DUPLICATE;
        end else if (has_free) begin
          way_live[free_slot] = 1'b1;
          way_key[free_slot]  = b.key;
          way_data[free_slot] = b.value_in;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (found) begin
          r.hit           = 1'b1;
          way_live[match] = 1'b0;
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      // the spare code behaves as a lookup
      default: begin
        if (found) begin
          r.hit       = 1'b1;
          r.value_out = way_data[match];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) way_live[i] = 1'b0;
      width_reg = HASH_BITS_RST;
      due_results.delete();
      errs = 0;
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) width_reg = cfg_data;
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result beat: hit %0b value %h status %0d",
                     out_pld.hit, out_pld.value_out, out_pld.status);
        end else begin
          want = due_results.pop_front();
          if (want.hit !== out_pld.hit || want.value_out !== out_pld.value_out ||
              want.status !== out_pld.status) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: exp hit %0b val %h st %0d, got hit %0b val %h st %0d",
                       want.hit, want.value_out, want.status,
                       out_pld.hit, out_pld.value_out, out_pld.status);
          end
        end
      end
      if (in_valid && !in_stall) due_results.push_back(table_access(in_pld));
      pending    <= due_results.size();
      fail_count <= errs;
    end
  end

endmodule

// ----- bench/tb_integer_key_hash_table.sv -----
// testbench top of the integer key hash table: drives beats and settings, gives the verdict
module tb_integer_key_hash_table;
  import ikht_pkg::*;

  // the unused op code, expected to act as a lookup
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 180;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_pld;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_pld;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;
  int          fail_count;
  int          pending;

  int unsigned gap_odds = 20;
  int unsigned cycles = 0;
  int unsigned pool_n = 16;
  logic [31:0] key_pool [64];
  logic [3:0]  width_plan [8] = '{4'd1, 4'd0, 4'd3, 4'd15, 4'd7, 4'd2, 4'd5, 4'd10};

  integer_key_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pld    (in_pld),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pld   (out_pld),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ikht_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pld     (in_pld),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_pld    (out_pld),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_integer_key_hash_table NOT OK");
      $finish;
    end
  end

  // result side backpressure in bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < gap_odds) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic put_beat(logic [1:0] op, logic [31:0] key, logic [31:0] val);
    in_beat_t b;
    b.op       = op;
    b.key      = key;
    b.value_in = val;
    if ($urandom_range(0, 99) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pld   <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // returns once every predicted result beat has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_width(logic [3:0] w);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned r;
    int unsigned n;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_pld    <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // extreme keys and values, every outcome of each op but a full bucket at the reset width
    put_beat(OP_LOOKUP, 32'h0, 32'h0);
    put_beat(OP_ADD, 32'h0, 32'hffff_ffff);
    put_beat(OP_ADD, 32'hffff_ffff, 32'h0);
    put_beat(OP_LOOKUP, 32'h0, 32'h0);
    put_beat(OP_SPARE, 32'hffff_ffff, 32'hffff_ffff);
    put_beat(OP_ADD, 32'h0, 32'h1234_5678);
    put_beat(OP_LOOKUP, 32'h0, 32'h0);
    put_beat(OP_DELETE, 32'h0, 32'h0);
    put_beat(OP_DELETE, 32'h0, 32'h0);
    put_beat(OP_LOOKUP, 32'h0, 32'h0);
    put_beat(OP_DELETE, 32'hffff_ffff, 32'h0);

    // two buckets and nine keys: at least one add finds its bucket full
    drain();
    set_width(4'd1);
    for (int i = 0; i < 9; i++) put_beat(OP_ADD, key_pool[i], $urandom());
    put_beat(OP_SPARE, key_pool[8], 32'h0);
    put_beat(OP_DELETE, key_pool[0], 32'h0);
    put_beat(OP_ADD, key_pool[8], $urandom());

    foreach (width_plan[p]) begin
      drain();
      set_width(width_plan[p]);
      gap_odds = (p == 3 || p == 7) ? 0 : $urandom_range(10, 40);
      pool_n   = (width_plan[p] <= 4'd2) ? 10 : $urandom_range(16, 64);
      repeat (4) key_pool[$urandom_range(0, 63)] = $urandom();
      repeat (PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          // stray keys: mostly misses, kept out of the table
          n = $urandom_range(0, 2);
          put_beat(n == 0 ? OP_LOOKUP : n == 1 ? OP_DELETE : OP_SPARE,
                   $urandom(), $urandom());
        end else begin
          put_beat(r < 45 ? OP_ADD : r < 70 ? OP_LOOKUP : r < 92 ? OP_DELETE : OP_SPARE,
                   key_pool[$urandom_range(0, pool_n - 1)], $urandom());
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("tb_integer_key_hash_table OK");
    else
      $display("tb_integer_key_hash_table NOT OK");
    $finish;
  end

endmodule
